### src/bwr_pkg.sv
// Shared constants and types for the bitmap word to row id converter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package bwr_pkg;
	localparam int WORD_BITS = 31;
	localparam int ROW_BITS  = 40;
	localparam int VALID_W   = 5;
	localparam int LANE_BITS = 8;
	localparam int NUM_LANES = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
	localparam int OFF_W     = $clog2(WORD_BITS);
	localparam int SHIFT_W   = $clog2(WORD_BITS + 1);
	localparam int LPOS_W    = $clog2(LANE_BITS);

	typedef struct packed {
		logic              hit;
		logic [LPOS_W-1:0] pos;
	} lane_hit_t;

	typedef struct packed {
		logic             any;
		logic [OFF_W-1:0] off;
	} find_t;
endpackage
`default_nettype wire

### src/bwr_word_if.sv
// Input channel: one literal bitmap word per beat.
// Depends on bwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bwr_word_if;
	import bwr_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] literal_bits;
	logic [VALID_W-1:0]   valid_bits;
	logic                 final_word;

	modport source (output valid, literal_bits, valid_bits, final_word, input ready);
	modport sink   (input valid, literal_bits, valid_bits, final_word, output ready);
endinterface
`default_nettype wire

### src/bwr_row_if.sv
// Output channel: one row id per beat.
// Depends on bwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bwr_row_if;
	import bwr_pkg::*;
	logic                valid;
	logic                ready;
	logic [ROW_BITS-1:0] row_id;
	logic                row_valid;
	logic                last_of_word;
	logic                end_of_list;

	modport source (output valid, row_id, row_valid, last_of_word, end_of_list, input ready);
	modport sink   (input valid, row_id, row_valid, last_of_word, end_of_list, output ready);
endinterface
`default_nettype wire

### src/bitmap_word_to_row_ids_core.sv
// Top level of the bitmap word to row id converter.
// Depends on bwr_pkg, bwr_word_if, bwr_row_if, bwr_lane and bwr_merge.
//
// Usage:
//   word (sink): one literal word per beat; bit WORD_BITS-1 is the earliest row.
//     final_word closes the bitmap; on a final word only the low valid_bits
//     bits count and they are read as if aligned to the top of the word.
//   row (source): one row id per beat, ascending. last_of_word marks the last
//     beat of an input word, end_of_list the last beat of the bitmap. An empty
//     final word gives one end marker with row_valid low. An empty non-final
//     word gives no beat.
// Path: the first row id of a word goes from the search stage through the
//   offset stage into the output register, which drives row.
// Throughput: one set bit per cycle, while the offset stage can take it, is
//   found by NUM_LANES lanes of LANE_BITS bits and a merge stage; the next
//   word is taken in the cycle its last set bit, or its lack of one, is found.
// Reset: empties the pipeline and clears the running row base to zero.
// Stall: when row is not ready the pipeline holds; the output register and
//   the offset stage behind it stay full, the search stage keeps its word or,
//   if empty, takes one more, and then the word input stops.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_word_to_row_ids_core (
	input wire logic  clk,
	input wire logic  arst_n,
	bwr_word_if.sink  word,
	bwr_row_if.source row
);
	import bwr_pkg::*;

	// search stage
	logic                 busy_q;
	logic [WORD_BITS-1:0] bits_q;
	logic [ROW_BITS-1:0]  wbase_q;
	logic                 fin_q;
	logic [ROW_BITS-1:0]  nbase_q;

	// offset stage
	logic                 vld_s2;
	logic [ROW_BITS-1:0]  base_s2;
	logic [OFF_W-1:0]     off_s2;
	logic                 rv_s2;
	logic                 last_s2;
	logic                 eol_s2;

	// output register
	logic                 out_vld_q;
	logic [ROW_BITS-1:0]  row_id_q;
	logic                 rv_q;
	logic                 last_q;
	logic                 eol_q;

	logic [SHIFT_W-1:0]   vcnt;
	logic [WORD_BITS-1:0] aligned;
	logic [ROW_BITS:0]    nbase_sum;
	logic [ROW_BITS-1:0]  nbase_next;
	logic [NUM_LANES*LANE_BITS-1:0] ord;
	lane_hit_t [NUM_LANES-1:0]      hits;
	find_t                found;
	logic [WORD_BITS-1:0] one_hot;
	logic [WORD_BITS-1:0] rest;
	logic                 single;
	logic                 out_rdy;
	logic                 s2_rdy;
	logic                 step;
	logic                 emit;
	logic                 done;
	logic                 acc;
	logic [ROW_BITS:0]    row_sum;

	// clamp the valid count and move the valid bits to the top
	always_comb begin
		if (!word.final_word) begin
			vcnt = SHIFT_W'(WORD_BITS);
		end else if (int'(word.valid_bits) > WORD_BITS) begin
			vcnt = SHIFT_W'(WORD_BITS);
		end else begin
			vcnt = SHIFT_W'(word.valid_bits);
		end
		aligned = word.literal_bits << (SHIFT_W'(WORD_BITS) - vcnt);
	end

	assign nbase_sum  = {1'b0, nbase_q} + (ROW_BITS + 1)'(WORD_BITS);
	assign nbase_next = nbase_sum[ROW_BITS] ? '1 : nbase_sum[ROW_BITS-1:0];

	// lanes see the word in offset order, earliest row first
	always_comb begin
		ord = '0;
		for (int o = 0; o < WORD_BITS; o++) begin
			ord[o] = bits_q[WORD_BITS-1-o];
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		bwr_lane u_lane (
			.lane_bits (ord[l*LANE_BITS +: LANE_BITS]),
			.result    (hits[l])
		);
	end

	bwr_merge u_merge (
		.hits  (hits),
		.found (found)
	);

	assign one_hot = {1'b1, {(WORD_BITS-1){1'b0}}} >> found.off;
	assign rest    = bits_q & ~one_hot;
	assign single  = (bits_q & (bits_q - 1'b1)) == '0;

	assign out_rdy = !out_vld_q || row.ready;
	assign s2_rdy  = !vld_s2 || out_rdy;
	assign step    = busy_q && s2_rdy;
	assign emit    = step && (found.any || fin_q);
	assign done    = step && (!found.any || single);

	assign word.ready = !busy_q || done;
	assign acc        = word.valid && word.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			nbase_q <= '0;
		end else begin
			if (acc) begin
				busy_q  <= 1'b1;
				nbase_q <= word.final_word ? '0 : nbase_next;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			bits_q  <= aligned;
			wbase_q <= nbase_q;
			fin_q   <= word.final_word;
		end else if (step && found.any) begin
			bits_q <= rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s2_rdy) begin
				vld_s2 <= emit;
			end
			if (out_rdy) begin
				out_vld_q <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_rdy) begin
			base_s2 <= found.any ? wbase_q : '0;
			off_s2  <= found.any ? found.off : '0;
			rv_s2   <= found.any;
			last_s2 <= !found.any || single;
			eol_s2  <= fin_q && (!found.any || single);
		end
	end

	assign row_sum = {1'b0, base_s2} + (ROW_BITS + 1)'(off_s2);

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			row_id_q <= row_sum[ROW_BITS] ? '1 : row_sum[ROW_BITS-1:0];
			rv_q     <= rv_s2;
			last_q   <= last_s2;
			eol_q    <= eol_s2;
		end
	end

	assign row.valid        = out_vld_q;
	assign row.row_id       = row_id_q;
	assign row.row_valid    = rv_q;
	assign row.last_of_word = last_q;
	assign row.end_of_list  = eol_q;
endmodule
`default_nettype wire

### src/bwr_lane.sv
// One search lane: finds the earliest set bit in its slice of the word.
// Depends on bwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bwr_lane (
	input  wire logic [bwr_pkg::LANE_BITS-1:0] lane_bits,
	output bwr_pkg::lane_hit_t                 result
);
	import bwr_pkg::*;

	always_comb begin
		result = '0;
		// scan downward so the lowest index wins
		for (int i = LANE_BITS - 1; i >= 0; i--) begin
			if (lane_bits[i]) begin
				result.hit = 1'b1;
				result.pos = LPOS_W'(i);
			end
		end
	end
endmodule
`default_nettype wire

### src/bwr_merge.sv
// Merges the lane results: picks the first lane with a hit and forms the offset.
// Depends on bwr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bwr_merge (
	input  bwr_pkg::lane_hit_t [bwr_pkg::NUM_LANES-1:0] hits,
	output bwr_pkg::find_t                              found
);
	import bwr_pkg::*;

	always_comb begin
		found = '0;
		for (int l = NUM_LANES - 1; l >= 0; l--) begin
			if (hits[l].hit) begin
				found.any = 1'b1;
				found.off = OFF_W'(l * LANE_BITS) + OFF_W'(hits[l].pos);
			end
		end
	end
endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking bench for bitmap_word_to_row_ids_core: a directed table, then random bitmaps.
// Expected rows: an in-bench expansion of each accepted word, or the table row if typed.
// Depends on bwr_pkg, bwr_word_if, bwr_row_if and the core.
`timescale 1ns / 1ps
module testbench;
	import bwr_pkg::*;

	localparam int IDLE_PCT     = 33;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [ROW_BITS-1:0] row_id;
		logic                row_valid;
		logic                last_of_word;
		logic                end_of_list;
	} row_beat_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] lit;
		logic [VALID_W-1:0]   vb;
		logic                 fin;
		logic                 typed;
		row_beat_t            exp;
	} word_case_t;

	localparam row_beat_t END_MARK = '{'0, 1'b0, 1'b1, 1'b1};
	localparam row_beat_t NO_ROW   = '0;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bwr_word_if word_ch ();
	bwr_row_if  row_ch ();

	bitmap_word_to_row_ids_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.word   (word_ch),
		.row    (row_ch)
	);

	always #5 clk = ~clk;

	row_beat_t           rows_due [$];
	logic [ROW_BITS-1:0] row_base = '0;
	int                  mismatches = 0;
	int                  cycles = 0;
	int                  holds_asked = 0;
	bit                  quiet = 1'b0;

	// Typed rows give a single beat that can be read off directly; the rest are predicted.
	word_case_t directed_words [19] = '{
		'{31'h00000000, 5'd31, 1'b1, 1'b1, END_MARK},
		'{31'h00000001, 5'd1,  1'b1, 1'b1, '{40'd0, 1'b1, 1'b1, 1'b1}},
		'{31'h7fffffff, 5'd0,  1'b1, 1'b1, END_MARK},
		'{31'h7fffffe0, 5'd5,  1'b1, 1'b1, END_MARK},
		'{31'h00000010, 5'd5,  1'b1, 1'b1, '{40'd0, 1'b1, 1'b1, 1'b1}},
		'{31'h7fffffff, 5'd0,  1'b0, 1'b0, NO_ROW},
		'{31'h00000000, 5'd31, 1'b0, 1'b0, NO_ROW},
		'{31'h40000000, 5'd17, 1'b0, 1'b0, NO_ROW},
		'{31'h00000001, 5'd31, 1'b0, 1'b0, NO_ROW},
		'{31'h2aaaaaaa, 5'd31, 1'b0, 1'b0, NO_ROW},
		'{31'h55555555, 5'd31, 1'b0, 1'b0, NO_ROW},
		'{31'h4ccccccc, 5'd31, 1'b0, 1'b0, NO_ROW},
		'{31'h33333333, 5'd31, 1'b0, 1'b0, NO_ROW},
		'{31'h70f0f0f0, 5'd31, 1'b0, 1'b0, NO_ROW},
		'{31'h0f0f0f0f, 5'd31, 1'b1, 1'b0, NO_ROW},
		'{31'h7fffffff, 5'd31, 1'b1, 1'b0, NO_ROW},
		'{31'h00000000, 5'd0,  1'b0, 1'b0, NO_ROW},
		'{31'h00000000, 5'd16, 1'b1, 1'b1, END_MARK},
		'{31'h00000001, 5'd31, 1'b1, 1'b1, '{40'd30, 1'b1, 1'b1, 1'b1}}
	};

	function automatic logic [ROW_BITS-1:0] sat_add(logic [ROW_BITS-1:0] a, int unsigned b);
		logic [ROW_BITS:0] s;
		s = {1'b0, a} + b;
		return s[ROW_BITS] ? '1 : s[ROW_BITS-1:0];
	endfunction

	// Expand one word into its row beats and advance the running base.
	function automatic void expand_word_rows(logic [WORD_BITS-1:0] lit, logic [VALID_W-1:0] vb,
			logic fin, bit record);
		int unsigned span;
		row_beat_t   held;
		bit          have;
		span = fin ? ((vb > WORD_BITS) ? WORD_BITS : vb) : WORD_BITS;
		have = 1'b0;
		held = NO_ROW;
		for (int off = 0; off < span; off++) begin
			if (lit[span - 1 - off]) begin
				if (have && record)
					rows_due.push_back(held);
				held = '{sat_add(row_base, off), 1'b1, 1'b0, 1'b0};
				have = 1'b1;
			end
		end
		if (record) begin
			if (have) begin
				held.last_of_word = 1'b1;
				held.end_of_list  = fin;
				rows_due.push_back(held);
			end else if (fin) begin
				rows_due.push_back(END_MARK);
			end
		end
		row_base = fin ? '0 : sat_add(row_base, WORD_BITS);
	endfunction

	function automatic logic [WORD_BITS-1:0] random_literal();
		logic [WORD_BITS-1:0] v;
		v = '0;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2, 3: begin
				repeat ($urandom_range(1, 3))
					v[$urandom_range(0, WORD_BITS - 1)] = 1'b1;
			end
			4: begin
				v = '1;
				repeat ($urandom_range(1, 3))
					v[$urandom_range(0, WORD_BITS - 1)] = 1'b0;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Called at a rising edge; returns at the edge that accepts the beat.
	task automatic send_word(logic [WORD_BITS-1:0] lit, logic [VALID_W-1:0] vb, logic fin,
			bit typed, row_beat_t exp, bit idle_on);
		while (idle_on && !quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			word_ch.valid <= 1'b0;
			@(posedge clk);
		end
		word_ch.valid        <= 1'b1;
		word_ch.literal_bits <= lit;
		word_ch.valid_bits   <= vb;
		word_ch.final_word   <= fin;
		do @(posedge clk); while (!word_ch.ready);
		expand_word_rows(lit, vb, fin, !typed);
		if (typed)
			rows_due.push_back(exp);
	endtask

	// Mostly whole bitmaps of a few words; a lone final word stands in for a broken one.
	task automatic send_bitmaps(int count, bit idle_on);
		int sent;
		int words;
		sent = 0;
		while (sent < count) begin
			words = $urandom_range(1, 5);
			for (int w = 0; w < words; w++) begin
				if (w == words - 1)
					send_word(random_literal(),
						($urandom_range(0, 3) == 0) ? WORD_BITS : $urandom_range(0, WORD_BITS),
						1'b1, 1'b0, NO_ROW, idle_on);
				else
					send_word(random_literal(), $urandom, 1'b0, 1'b0, NO_ROW, idle_on);
				sent++;
			end
		end
	endtask

	initial begin
		word_ch.valid        <= 1'b0;
		word_ch.literal_bits <= '0;
		word_ch.valid_bits   <= '0;
		word_ch.final_word   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!arst_n);

		foreach (directed_words[i])
			send_word(directed_words[i].lit, directed_words[i].vb, directed_words[i].fin,
				directed_words[i].typed, directed_words[i].exp, 1'b1);
		send_bitmaps(60, 1'b1);

		// Let the block run dry before the receiver holds off.
		word_ch.valid <= 1'b0;
		do @(posedge clk); while (rows_due.size() != 0);
		holds_asked++;
		send_bitmaps(40, 1'b0);

		quiet = 1'b1;
		send_bitmaps(50, 1'b1);
		quiet = 1'b0;
		send_bitmaps(50, 1'b1);
		word_ch.valid <= 1'b0;

		do @(posedge clk); while (rows_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Receiver: random stalls, quiet stretches and one long hold-off on request.
	initial begin
		int holds_done;
		int hold_left;
		holds_done = 0;
		hold_left  = 0;
		row_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				row_ch.ready <= 1'b0;
			end else begin
				row_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	task automatic log_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		row_beat_t got;
		row_beat_t want;
		if (arst_n && row_ch.valid && row_ch.ready) begin
			got = '{row_ch.row_id, row_ch.row_valid, row_ch.last_of_word, row_ch.end_of_list};
			if (rows_due.size() == 0) begin
				log_mismatch($sformatf("unexpected row beat: id %0d valid %0b last %0b end %0b",
					got.row_id, got.row_valid, got.last_of_word, got.end_of_list));
			end else begin
				want = rows_due.pop_front();
				if (got !== want)
					log_mismatch($sformatf(
						"row beat: id %0d/%0d valid %0b/%0b last %0b/%0b end %0b/%0b (exp/act)",
						want.row_id, got.row_id, want.row_valid, got.row_valid,
						want.last_of_word, got.last_of_word, want.end_of_list, got.end_of_list));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end
endmodule
